/* src/spq_pkg.sv */
// spq_pkg: shared types and constants of the sorted priority queue
// used by spq_cell, spq_outq, sorted_priority_queue and tb; no dependencies
package spq_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FIELD_CNT_W = 8;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                     ins;
    logic                     pop;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    status_t                  status;
    logic [FIELD_CNT_W-1:0]   entry_count;
  } result_t;

endpackage

/* src/spq_cell.sv */
// spq_cell: one slot of the shift-register priority queue
// depends on spq_pkg
module spq_cell (
  input  logic                              clk,
  input  spq_pkg::cell_cmd_t                cmd,
  input  logic                              occupied,
  input  logic                              prev_gt,
  input  logic signed [spq_pkg::DATA_W-1:0] prev_val,
  input  logic signed [spq_pkg::DATA_W-1:0] prev_pri,
  input  logic signed [spq_pkg::DATA_W-1:0] next_val,
  input  logic signed [spq_pkg::DATA_W-1:0] next_pri,
  output logic signed [spq_pkg::DATA_W-1:0] val,
  output logic signed [spq_pkg::DATA_W-1:0] pri,
  output logic                              gt
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] pri_r, pri_nxt;

  // empty slots count as greater so the new entry lands at the first of them
  assign gt = !occupied || (pri_r > cmd.prio);

  always_comb begin
    val_nxt = val_r;
    pri_nxt = pri_r;
    if (cmd.ins && gt) begin
      if (prev_gt) begin
        val_nxt = prev_val;
        pri_nxt = prev_pri;
      end else begin
        val_nxt = cmd.value;
        pri_nxt = cmd.prio;
      end
    end else if (cmd.pop) begin
      val_nxt = next_val;
      pri_nxt = next_pri;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pri_r <= pri_nxt;
  end

  assign val = val_r;
  assign pri = pri_r;

endmodule

/* src/spq_outq.sv */
// spq_outq: two-entry result queue between the cell row and the result port
// depends on spq_pkg
module spq_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  spq_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output spq_pkg::result_t out_data
);
  import spq_pkg::*;

  logic    head_v_r, head_v_nxt;
  logic    tail_v_r, tail_v_nxt;
  result_t head_d_r, head_d_nxt;
  result_t tail_d_r, tail_d_nxt;
  logic    pop;

  assign pop = head_v_r && !out_stall;

  always_comb begin
    head_v_nxt = head_v_r && !pop;
    head_d_nxt = head_d_r;
    tail_v_nxt = tail_v_r;
    tail_d_nxt = tail_d_r;
    if (!head_v_nxt && tail_v_nxt) begin
      head_v_nxt = 1'b1;
      head_d_nxt = tail_d_r;
      tail_v_nxt = 1'b0;
    end
    if (push) begin
      if (!head_v_nxt) begin
        head_v_nxt = 1'b1;
        head_d_nxt = push_data;
      end else begin
        tail_v_nxt = 1'b1;
        tail_d_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_d_r <= head_d_nxt;
    tail_d_r <= tail_d_nxt;
  end

  assign full      = tail_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_d_r;

endmodule

/* src/sorted_priority_queue.sv */
// sorted_priority_queue: top level, a row of spq_cell slots plus a result queue
// depends on spq_pkg, spq_cell and spq_outq
//
//   channel   direction  handshake           payload
//   in_       request    in_valid/in_stall   func, item_value, item_priority
//   out_      result     out_valid/out_stall removed_value, status, entry_count
//
// one request per cycle while not stalled; the result queue registers its result
// each cycle's figure is set by the 32-bit priority compare in every cell
// against the broadcast priority, plus the pick from the neighbor slot
// reset clears the entry count and the result queue; slot contents need none
// in_stall rises only when two results wait in the result queue
// entries move in one step: insert shifts larger ones back, remove shifts forward
module sorted_priority_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic signed [spq_pkg::DATA_W-1:0] in_item_value,
  input  logic signed [spq_pkg::DATA_W-1:0] in_item_priority,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [spq_pkg::DATA_W-1:0] out_removed_value,
  output logic [1:0]                        out_status,
  output logic [spq_pkg::FIELD_CNT_W-1:0]   out_entry_count
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic             is_full, is_empty;
  logic             do_ins, do_pop;
  cell_cmd_t        cmd;
  result_t          res, out_res;
  logic             q_full;

  // per-slot wires; slot 0 is the front of the queue
  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] cell_pri [CAPACITY];
  logic                     cell_gt  [CAPACITY];
  logic                     cell_occ [CAPACITY];

  // widened count so the 8-bit field works at any capacity
  logic [CNT_W+FIELD_CNT_W-1:0] count_ext;

  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign do_ins   = accept && (in_func == FUNC_INSERT) && !is_full;
  assign do_pop   = accept && (in_func == FUNC_REMOVE) && !is_empty;

  assign cmd.ins   = do_ins;
  assign cmd.pop   = do_pop;
  assign cmd.value = in_item_value;
  assign cmd.prio  = in_item_priority;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_gt;
    logic signed [DATA_W-1:0] prev_val, prev_pri, next_val, next_pri;

    assign cell_occ[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_front
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
      assign prev_pri = '0;
    end else begin : g_mid
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
      assign prev_pri = cell_pri[i-1];
    end

    // last slot keeps its own data on remove; it falls out of the count anyway
    if (i == CAPACITY - 1) begin : g_back
      assign next_val = cell_val[i];
      assign next_pri = cell_pri[i];
    end else begin : g_inner
      assign next_val = cell_val[i+1];
      assign next_pri = cell_pri[i+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .occupied (cell_occ[i]),
      .prev_gt  (prev_gt),
      .prev_val (prev_val),
      .prev_pri (prev_pri),
      .next_val (next_val),
      .next_pri (next_pri),
      .val      (cell_val[i]),
      .pri      (cell_pri[i]),
      .gt       (cell_gt[i])
    );
  end

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // accepted request's result: value and status pre-shift, entry count post-shift
  assign count_ext = {{FIELD_CNT_W{1'b0}}, count_nxt};

  always_comb begin
    res.removed_value = '0;
    res.status        = ST_DONE;
    res.entry_count   = count_ext[FIELD_CNT_W-1:0];
    if (in_func == FUNC_INSERT) begin
      if (is_full) begin
        res.status = ST_FULL;
      end
    end else begin
      if (is_empty) begin
        res.status        = ST_EMPTY;
        res.removed_value = EMPTY_VALUE;
      end else begin
        res.removed_value = cell_val[0];
      end
    end
  end

  spq_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  assign in_stall          = q_full;
  assign out_removed_value = out_res.removed_value;
  assign out_status        = out_res.status;
  assign out_entry_count   = out_res.entry_count;

  // the count never passes the number of slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a remove from a non-empty queue takes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == FUNC_REMOVE && count_r != '0)
      |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not lower the count by one");

  // the front two entries stay in priority order
  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (cell_pri[0] <= cell_pri[1]))
    else $error("front entries out of order");

  // the result queue only backs up after its head is occupied
  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("request stalled with no result waiting");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for sorted_priority_queue, random and directed requests
// depends on spq_pkg and the sorted_priority_queue rtl; predicts every result in-line
module tb;
  import spq_pkg::*;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } request_t;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_func = FUNC_INSERT;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic signed [DATA_W-1:0] in_item_priority = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_removed_value;
  logic [1:0]               out_status;
  logic [FIELD_CNT_W-1:0]   out_entry_count;

  // requests waiting for the driver, and results still owed by the queue
  request_t req_q[$];
  result_t  owed_q[$];

  // shadow copy of the queue contents, kept sorted like the block
  logic signed [DATA_W-1:0] model_val[CAPACITY];
  logic signed [DATA_W-1:0] model_pri[CAPACITY];
  int                       model_count = 0;

  int fail_cnt = 0;
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int gen_count = 0;     // entry count as the generator sees it
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit in_took = 1'b0;

  sorted_priority_queue u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_removed_value(out_removed_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  always #5 clk = ~clk;

  // work out the result of one request and update the shadow queue
  function automatic result_t queue_step(request_t req);
    result_t res;
    int      pos;
    res.removed_value = '0;
    res.status        = ST_DONE;
    if (req.func == FUNC_INSERT) begin
      if (model_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // new entry lands behind every entry of equal or smaller priority
        pos = model_count;
        while (pos > 0 && model_pri[pos-1] > req.prio) begin
          model_val[pos] = model_val[pos-1];
          model_pri[pos] = model_pri[pos-1];
          pos--;
        end
        model_val[pos] = req.value;
        model_pri[pos] = req.prio;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        res.status        = ST_EMPTY;
        res.removed_value = EMPTY_VALUE;
      end else begin
        res.removed_value = model_val[0];
        for (int k = 0; k + 1 < model_count; k++) begin
          model_val[k] = model_val[k+1];
          model_pri[k] = model_pri[k+1];
        end
        model_count--;
      end
    end
    res.entry_count = model_count[FIELD_CNT_W-1:0];
    return res;
  endfunction

  // driver: new request after the previous one was taken, payload held while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (in_valid && !in_took) begin
        // stalled: keep valid and payload as they are
      end else begin
        in_took = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0 && in_idle_pct != 0 &&
                     $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          request_t req;
          req = req_q.pop_front();
          in_valid         <= 1'b1;
          in_func          <= req.func;
          in_item_value    <= req.value;
          in_item_priority <= req.prio;
        end else begin
          in_valid <= 1'b0;
        end
      end
      // result side back-pressure in bursts
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: check the result leaving, then predict for the request entering
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (owed_q.size() == 0) begin
          $display("%0t: result with no request pending, got value %0d status %0d count %0d",
                   $time, out_removed_value, out_status, out_entry_count);
          fail_cnt++;
        end else begin
          result_t want;
          want = owed_q.pop_front();
          if (out_removed_value !== want.removed_value) begin
            $display("%0t: removed_value mismatch, expected %0d, got %0d",
                     $time, want.removed_value, out_removed_value);
            fail_cnt++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_status);
            fail_cnt++;
          end
          if (out_entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d, got %0d",
                     $time, want.entry_count, out_entry_count);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        request_t req;
        req.func  = in_func;
        req.value = in_item_value;
        req.prio  = in_item_priority;
        owed_q.push_back(queue_step(req));
        accepted_cnt++;
        in_took = 1'b1;
      end
    end
  end

  // hand one request to the driver; the generator keeps its own entry count
  task automatic queue_request(logic func, logic signed [DATA_W-1:0] value,
                               logic signed [DATA_W-1:0] prio);
    request_t req;
    req.func  = func;
    req.value = value;
    req.prio  = prio;
    req_q.push_back(req);
    queued_cnt++;
    if (func == FUNC_INSERT && gen_count < CAPACITY) gen_count++;
    if (func == FUNC_REMOVE && gen_count > 0) gen_count--;
  endtask

  // often a narrow band so ties are common, sometimes the extremes, else any value
  function automatic logic signed [DATA_W-1:0] pick_prio();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return $signed($urandom_range(0, 15)) - 8;
    if (sel < 60) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
    return $urandom();
  endfunction

  task automatic random_request(int ins_pct);
    if ($urandom_range(0, 99) < ins_pct) queue_request(FUNC_INSERT, pick_value(), pick_prio());
    else queue_request(FUNC_REMOVE, pick_value(), pick_prio());
  endtask

  // block until every queued request has been taken and answered
  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || owed_q.size() != 0) @(negedge clk);
  endtask

  task automatic pick_idling();
    int rates[4] = '{0, 3, 10, 30};
    in_idle_pct  = rates[$urandom_range(0, 3)];
    out_idle_pct = rates[$urandom_range(0, 3)];
  endtask

  initial begin
    int seg;
    int n;
    int ins_pct;
    int rand_start;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: remove when empty, extreme fields, ties in arrival order
    in_idle_pct  = 10;
    out_idle_pct = 10;
    queue_request(FUNC_REMOVE, 32'sh5555_5555, 32'shAAAA_AAAA);
    queue_request(FUNC_INSERT, VAL_MAX, VAL_MAX);
    queue_request(FUNC_INSERT, VAL_MIN, VAL_MIN);
    queue_request(FUNC_INSERT, 0, 0);
    queue_request(FUNC_INSERT, -1, -1);
    queue_request(FUNC_INSERT, 1, 5);
    queue_request(FUNC_INSERT, 2, 5);
    queue_request(FUNC_INSERT, 32'sh5555_5555, 5);
    queue_request(FUNC_INSERT, 32'shAAAA_AAAA, VAL_MIN);
    queue_request(FUNC_INSERT, 9, VAL_MAX);
    repeat (10) queue_request(FUNC_REMOVE, 32'shAAAA_AAAA, 32'sh5555_5555);
    queue_request(FUNC_REMOVE, VAL_MAX, VAL_MIN);

    // hold the sender until the block has answered everything
    wait_drained();

    // random: alternate full fills, full drains and mixed stretches
    rand_start = queued_cnt;
    seg = 0;
    while (queued_cnt - rand_start < 1400) begin
      pick_idling();
      case (seg % 5)
        0: begin
          while (gen_count < CAPACITY) random_request(100);
          n = $urandom_range(2, 5);
          repeat (n) random_request(100);   // these land on a full queue
        end
        2: begin
          while (gen_count > 0) random_request(0);
          n = $urandom_range(1, 3);
          repeat (n) random_request(0);     // these land on an empty queue
        end
        default: begin
          case ($urandom_range(0, 2))
            0: ins_pct = 30;
            1: ins_pct = 50;
            default: ins_pct = 70;
          endcase
          n = $urandom_range(40, 120);
          repeat (n) random_request(ins_pct);
        end
      endcase
      seg++;
      if (seg % 7 == 0) wait_drained();
    end

    // closing stretch at full rate on both sides
    wait_drained();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (150) random_request(50);

    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_cnt == 0 && owed_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
